>>> src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and the character decoder of the bracket checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
    localparam int COUNT_W     = 16;
    localparam int CHAR_W      = 8;
    localparam int CODE_W      = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_ROUND  = 2'd0;
    localparam t_code CODE_SQUARE = 2'd1;
    localparam t_code CODE_CURLY  = 2'd2;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_code code;
    } t_char_class;

    typedef struct packed {
        logic  push;
        logic  pop;
        t_code code;
    } t_stack_op;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] ch);
        t_char_class c;
        c = '{is_open: 1'b0, is_close: 1'b0, code: CODE_ROUND};
        unique case (ch)
            CH_OPEN_ROUND:   c = '{is_open: 1'b1, is_close: 1'b0, code: CODE_ROUND};
            CH_OPEN_SQUARE:  c = '{is_open: 1'b1, is_close: 1'b0, code: CODE_SQUARE};
            CH_OPEN_CURLY:   c = '{is_open: 1'b1, is_close: 1'b0, code: CODE_CURLY};
            CH_CLOSE_ROUND:  c = '{is_open: 1'b0, is_close: 1'b1, code: CODE_ROUND};
            CH_CLOSE_SQUARE: c = '{is_open: 1'b0, is_close: 1'b1, code: CODE_SQUARE};
            CH_CLOSE_CURLY:  c = '{is_open: 1'b0, is_close: 1'b1, code: CODE_CURLY};
            default:         c = '{is_open: 1'b0, is_close: 1'b0, code: CODE_ROUND};
        endcase
        return c;
    endfunction

endpackage

>>> src/bbc_cell.sv
// ----------------------------------------------------------------------------
// bbc_cell
// One stack slot: takes the code from above on a push, from below on a pop.
// ----------------------------------------------------------------------------
module bbc_cell (
    input  logic               i_clk,
    input  bbc_pkg::t_stack_op i_op,
    input  bbc_pkg::t_code     i_above,
    input  bbc_pkg::t_code     i_below,
    output bbc_pkg::t_code     o_code
);
    import bbc_pkg::*;

    t_code r_code;
    t_code n_code;

    always_comb begin
        n_code = r_code;
        if (i_op.push) begin
            n_code = i_above;
        end else if (i_op.pop) begin
            n_code = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_code = r_code;

endmodule

>>> src/bbc_stack.sv
// ----------------------------------------------------------------------------
// bbc_stack
// Shift-register stack: a chain of cells, cell 0 being the top of stack.
// ----------------------------------------------------------------------------
module bbc_stack (
    input  logic               i_clk,
    input  bbc_pkg::t_stack_op i_op,
    output bbc_pkg::t_code     o_top
);
    import bbc_pkg::*;

    t_code w_code [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_code w_above;
        t_code w_below;

        if (g == 0) begin : g_top
            assign w_above = i_op.code;
        end else begin : g_mid
            assign w_above = w_code[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_below = CODE_ROUND;
        end else begin : g_up
            assign w_below = w_code[g+1];
        end

        bbc_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (i_op),
            .i_above (w_above),
            .i_below (w_below),
            .o_code  (w_code[g])
        );
    end

    assign o_top = w_code[0];

endmodule

>>> src/bracket_balance_checker_core.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Checks a character stream for balanced (), [] and {} brackets per string.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   in      | to core   | i_in_valid / o_in_stall | i_char_code, i_is_last
//   out     | from core | o_out_valid / i_out_stall | o_balanced, o_bracket_count,
//           |           |                        | o_overflowed
//
// One character per cycle while o_in_stall is low; push and pop move the whole
// cell chain in one step, and only the top cell is compared. The verdict of a
// string appears in the output register the cycle after its last character is
// accepted. Synchronous reset clears fill, count and flags; the stack cells need
// no clearing. Characters that are not last always flow; a last character is
// held only while a verdict is still stalled.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bbc_pkg::CHAR_W-1:0] i_char_code,
    input  logic                      i_is_last,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_balanced,
    output logic [bbc_pkg::COUNT_W-1:0] o_bracket_count,
    output logic                      o_overflowed
);
    import bbc_pkg::*;

    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_mismatch;
    logic               n_mismatch;
    logic               r_overflow;
    logic               n_overflow;
    logic               r_out_valid;
    logic               r_balanced;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_overflow;

    t_char_class w_class;
    t_stack_op   w_op;
    t_code       w_top;
    logic        w_accept;
    logic        w_full;
    logic        w_empty;
    logic        w_match;
    logic        w_bracket;

    assign o_in_stall = r_out_valid && i_out_stall && i_is_last;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_class   = classify(i_char_code);
    assign w_full    = (r_fill == FILL_W'(STACK_DEPTH));
    assign w_empty   = (r_fill == '0);
    assign w_match   = (w_top == w_class.code);
    assign w_bracket = w_class.is_open || w_class.is_close;

    assign w_op.push = w_accept && w_class.is_open && !w_full;
    assign w_op.pop  = w_accept && w_class.is_close && !w_empty && w_match;
    assign w_op.code = w_class.code;

    bbc_stack u_stack (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_top (w_top)
    );

    always_comb begin
        n_fill     = r_fill;
        n_count    = r_count;
        n_mismatch = r_mismatch;
        n_overflow = r_overflow;
        if (w_accept) begin
            if (w_bracket && (r_count != COUNT_MAX)) begin
                n_count = r_count + COUNT_W'(1);
            end
            if (w_op.push) begin
                n_fill = r_fill + FILL_W'(1);
            end else if (w_op.pop) begin
                n_fill = r_fill - FILL_W'(1);
            end
            if (w_class.is_open && w_full) begin
                n_overflow = 1'b1;
            end
            if (w_class.is_close && (w_empty || !w_match)) begin
                n_mismatch = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_count     <= '0;
            r_mismatch  <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && i_is_last) begin
                r_fill      <= '0;
                r_count     <= '0;
                r_mismatch  <= 1'b0;
                r_overflow  <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                r_fill     <= n_fill;
                r_count    <= n_count;
                r_mismatch <= n_mismatch;
                r_overflow <= n_overflow;
                if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_is_last) begin
            r_balanced     <= !n_mismatch && !n_overflow && (n_fill == '0);
            r_out_count    <= n_count;
            r_out_overflow <= n_overflow;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_balanced      = r_balanced;
    assign o_bracket_count = r_out_count;
    assign o_overflowed    = r_out_overflow;

`ifndef SYNTHESIS
    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_op.push && w_op.pop))
        else $error("push and pop in the same cycle");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_is_last) |=> (o_out_valid && r_fill == '0 && r_count == '0
            && !r_mismatch && !r_overflow))
        else $error("last request did not give a verdict and clear state");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !(w_accept && i_is_last)) |=> !o_out_valid)
        else $error("verdict repeated after being taken");

    a_ovf_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflowed) |-> !o_balanced)
        else $error("overflowed string reported balanced");
`endif

endmodule
